>>> rtl/avr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package avr_pkg;

  localparam int unsigned K_W    = 32;  // unit axis component, Q1.30
  localparam int unsigned TRIG_W = 32;  // sine / cosine, Q1.30
  localparam int unsigned OMC_W  = 33;  // one minus cosine, Q2.30
  localparam int unsigned ROOT_W = 32;  // angle, Q3.28
  localparam int unsigned SQ_W   = 64;  // sum of squares, Q6.56
  localparam int unsigned QUO_W  = 31;  // axis magnitude quotient
  localparam int unsigned REM_W  = 63;  // divider partial remainder
  localparam int unsigned ANG_W  = 35;  // reduced angle, Q2.30 signed
  localparam int unsigned CORD_W = 36;  // cordic datapath
  localparam int unsigned FRAC_W = 30;

  localparam logic [30:0] ONE_Q30    = 31'd1073741824;
  localparam logic [32:0] TWOPI_Q30  = 33'd6746518852;
  localparam logic [33:0] TWOPI2_Q30 = 34'd13493037704;
  localparam logic [31:0] PI_Q30     = 32'd3373259426;
  localparam logic [30:0] HALFPI_Q30 = 31'd1686629713;
  localparam logic [29:0] CORDIC_X0  = 30'd652032874;
  localparam logic [31:0] MIN_ANGLE  = 32'd256;

  localparam logic [29:0] ATAN_TAB [10] = '{
    30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
    30'd33543516, 30'd16775851, 30'd8388437, 30'd4194283, 30'd2097149
  };

  typedef enum logic [1:0] {
    CFG_ROT_X = 2'd0,
    CFG_ROT_Y = 2'd1,
    CFG_ROT_Z = 2'd2
  } cfg_idx_e;

  // rotation coefficients, fixed while the rotation vector is unchanged
  typedef struct packed {
    logic signed [K_W-1:0]    k_x;
    logic signed [K_W-1:0]    k_y;
    logic signed [K_W-1:0]    k_z;
    logic signed [TRIG_W-1:0] sin_v;
    logic signed [TRIG_W-1:0] cos_v;
    logic signed [OMC_W-1:0]  omc;
    logic                     tiny;
  } coef_t;

  // arctangent step of cordic stage idx, Q2.30
  function automatic logic signed [CORD_W-1:0] atan_step(input int unsigned idx);
    logic signed [CORD_W-1:0] step;
    if (idx < 10) begin
      step = CORD_W'(ATAN_TAB[idx[3:0]]);
    end else if (idx <= 30) begin
      step = CORD_W'(64'd1 << (30 - idx));
    end else begin
      step = '0;
    end
    return step;
  endfunction

endpackage
`default_nettype wire

>>> rtl/avr_sqrt_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module avr_sqrt_cell #(
  parameter int unsigned BIT_POS = 62
) (
  input  wire logic                     clk_i,
  input  wire logic [avr_pkg::SQ_W-1:0] n_i,
  input  wire logic [avr_pkg::SQ_W-1:0] root_i,
  output logic      [avr_pkg::SQ_W-1:0] n_o,
  output logic      [avr_pkg::SQ_W-1:0] root_o
);
  import avr_pkg::*;

  localparam logic [SQ_W-1:0] BIT_VAL = SQ_W'(1) << BIT_POS;

  logic [SQ_W:0]   trial;
  logic [SQ_W-1:0] n_d, n_q, root_d, root_q;

  // one root bit per cell
  always_comb begin
    trial = {1'b0, root_i} + {1'b0, BIT_VAL};
    if ({1'b0, n_i} >= trial) begin
      n_d    = n_i - trial[SQ_W-1:0];
      root_d = (root_i >> 1) + BIT_VAL;
    end else begin
      n_d    = n_i;
      root_d = root_i >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q    <= n_d;
    root_q <= root_d;
  end

  assign n_o    = n_q;
  assign root_o = root_q;

endmodule
`default_nettype wire

>>> rtl/avr_div_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module avr_div_cell #(
  parameter int unsigned SHIFT = 0
) (
  input  wire logic                       clk_i,
  input  wire logic [avr_pkg::ROOT_W-1:0] divisor_i,
  input  wire logic [avr_pkg::REM_W-1:0]  rem_i,
  input  wire logic [avr_pkg::QUO_W-1:0]  quo_i,
  output logic      [avr_pkg::REM_W-1:0]  rem_o,
  output logic      [avr_pkg::QUO_W-1:0]  quo_o
);
  import avr_pkg::*;

  localparam logic [QUO_W-1:0] QBIT = QUO_W'(1) << SHIFT;

  logic [REM_W-1:0] dsh;
  logic [REM_W-1:0] rem_d, rem_q;
  logic [QUO_W-1:0] quo_d, quo_q;

  // restoring step for one quotient bit
  always_comb begin
    dsh = REM_W'(divisor_i) << SHIFT;
    if (rem_i >= dsh) begin
      rem_d = rem_i - dsh;
      quo_d = quo_i | QBIT;
    end else begin
      rem_d = rem_i;
      quo_d = quo_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign rem_o = rem_q;
  assign quo_o = quo_q;

endmodule
`default_nettype wire

>>> rtl/avr_cordic_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module avr_cordic_cell #(
  parameter int unsigned IDX = 0
) (
  input  wire logic                              clk_i,
  input  wire logic signed [avr_pkg::CORD_W-1:0] x_i,
  input  wire logic signed [avr_pkg::CORD_W-1:0] y_i,
  input  wire logic signed [avr_pkg::CORD_W-1:0] z_i,
  output logic signed      [avr_pkg::CORD_W-1:0] x_o,
  output logic signed      [avr_pkg::CORD_W-1:0] y_o,
  output logic signed      [avr_pkg::CORD_W-1:0] z_o
);
  import avr_pkg::*;

  localparam logic signed [CORD_W-1:0] STEP = atan_step(IDX);

  logic signed [CORD_W-1:0] dx, dy;
  logic signed [CORD_W-1:0] x_d, y_d, z_d, x_q, y_q, z_q;

  always_comb begin
    dx = y_i >>> IDX;
    dy = x_i >>> IDX;
    if (!z_i[CORD_W-1]) begin
      x_d = x_i - dx;
      y_d = y_i + dy;
      z_d = z_i - STEP;
    end else begin
      x_d = x_i + dx;
      y_d = y_i - dy;
      z_d = z_i + STEP;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;

endmodule
`default_nettype wire

>>> rtl/avr_coef.sv
`timescale 1ns / 1ps
`default_nettype none
module avr_coef #(
  parameter int unsigned CORDIC_STAGES = 24
) (
  input  wire logic           clk_i,
  input  wire logic [31:0]    rot_x_i,
  input  wire logic [31:0]    rot_y_i,
  input  wire logic [31:0]    rot_z_i,
  output avr_pkg::coef_t      coef_o
);
  import avr_pkg::*;

  localparam logic signed [ANG_W-1:0]  PI_S   = ANG_W'(PI_Q30);
  localparam logic signed [ANG_W-1:0]  HALF_S = ANG_W'(HALFPI_Q30);
  localparam logic signed [CORD_W-1:0] ONE_S  = CORD_W'(ONE_Q30);

  logic [31:0]     rot [3];
  logic [31:0]     mag [3];
  logic [SQ_W-1:0] sq_q [3];
  logic [SQ_W-1:0] sum_q;
  logic [SQ_W-1:0] sqn [ROOT_W+1];
  logic [SQ_W-1:0] sqr [ROOT_W+1];
  logic [ROOT_W-1:0] root;

  logic [REM_W-1:0] rem [3][QUO_W+1];
  logic [QUO_W-1:0] quo [3][QUO_W+1];

  logic [33:0]              a0;
  logic [32:0]              red_d, red_q;
  logic signed [ANG_W-1:0]  wrap_d, wrap_q, fold;
  logic                     neg_d, neg_q;
  logic signed [CORD_W-1:0] z0_q;
  logic signed [CORD_W-1:0] cx [CORDIC_STAGES+1];
  logic signed [CORD_W-1:0] cy [CORDIC_STAGES+1];
  logic signed [CORD_W-1:0] cz [CORDIC_STAGES+1];
  logic signed [CORD_W-1:0] xs, sin_c, cos_c;
  logic signed [K_W-1:0]    k_d [3];
  coef_t                    coef_d, coef_q;

  assign rot[0] = rot_x_i;
  assign rot[1] = rot_y_i;
  assign rot[2] = rot_z_i;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = rot[i][31] ? -rot[i] : rot[i];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      sq_q[i] <= mag[i] * mag[i];
    end
    sum_q <= sq_q[0] + sq_q[1] + sq_q[2];
  end

  // square root: one cell per root bit
  assign sqn[0] = sum_q;
  assign sqr[0] = '0;
  for (genvar j = 0; j < ROOT_W; j++) begin : g_root
    avr_sqrt_cell #(.BIT_POS(2 * (ROOT_W - 1 - j))) u_cell (
      .clk_i  (clk_i),
      .n_i    (sqn[j]),
      .root_i (sqr[j]),
      .n_o    (sqn[j+1]),
      .root_o (sqr[j+1])
    );
  end
  assign root = sqr[ROOT_W][ROOT_W-1:0];

  // axis normalization: three divider lanes, one quotient bit per cell
  for (genvar l = 0; l < 3; l++) begin : g_lane
    assign rem[l][0] = {1'b0, mag[l], {FRAC_W{1'b0}}};
    assign quo[l][0] = '0;
    for (genvar b = 0; b < QUO_W; b++) begin : g_bit
      avr_div_cell #(.SHIFT(QUO_W - 1 - b)) u_cell (
        .clk_i     (clk_i),
        .divisor_i (root),
        .rem_i     (rem[l][b]),
        .quo_i     (quo[l][b]),
        .rem_o     (rem[l][b+1]),
        .quo_o     (quo[l][b+1])
      );
    end
  end

  // angle reduction into the first quadrant pair
  always_comb begin
    a0 = {root, 2'b00};
    if (a0 >= TWOPI2_Q30) begin
      red_d = 33'(a0 - TWOPI2_Q30);
    end else if (a0 >= {1'b0, TWOPI_Q30}) begin
      red_d = 33'(a0 - {1'b0, TWOPI_Q30});
    end else begin
      red_d = a0[32:0];
    end
    if (red_q > {1'b0, PI_Q30}) begin
      wrap_d = ANG_W'(red_q) - ANG_W'(TWOPI_Q30);
    end else begin
      wrap_d = ANG_W'(red_q);
    end
    if (wrap_q > HALF_S) begin
      fold  = PI_S - wrap_q;
      neg_d = 1'b1;
    end else if (wrap_q < -HALF_S) begin
      fold  = -PI_S - wrap_q;
      neg_d = 1'b1;
    end else begin
      fold  = wrap_q;
      neg_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    red_q  <= red_d;
    wrap_q <= wrap_d;
    z0_q   <= CORD_W'(fold);
    neg_q  <= neg_d;
  end

  // sine and cosine: one cordic cell per iteration
  assign cx[0] = CORD_W'(CORDIC_X0);
  assign cy[0] = '0;
  assign cz[0] = z0_q;
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    avr_cordic_cell #(.IDX(i)) u_cell (
      .clk_i (clk_i),
      .x_i   (cx[i]),
      .y_i   (cy[i]),
      .z_i   (cz[i]),
      .x_o   (cx[i+1]),
      .y_o   (cy[i+1]),
      .z_o   (cz[i+1])
    );
  end

  always_comb begin
    xs = neg_q ? -cx[CORDIC_STAGES] : cx[CORDIC_STAGES];
    if (cy[CORDIC_STAGES] > ONE_S) begin
      sin_c = ONE_S;
    end else if (cy[CORDIC_STAGES] < -ONE_S) begin
      sin_c = -ONE_S;
    end else begin
      sin_c = cy[CORDIC_STAGES];
    end
    if (xs > ONE_S) begin
      cos_c = ONE_S;
    end else if (xs < -ONE_S) begin
      cos_c = -ONE_S;
    end else begin
      cos_c = xs;
    end
    for (int l = 0; l < 3; l++) begin
      k_d[l] = rot[l][31] ? -K_W'(quo[l][QUO_W]) : K_W'(quo[l][QUO_W]);
    end
    coef_d.k_x   = k_d[0];
    coef_d.k_y   = k_d[1];
    coef_d.k_z   = k_d[2];
    coef_d.sin_v = TRIG_W'(sin_c);
    coef_d.cos_v = TRIG_W'(cos_c);
    coef_d.omc   = OMC_W'(ONE_S - cos_c);
    coef_d.tiny  = root < MIN_ANGLE;
  end

  always_ff @(posedge clk_i) begin
    coef_q <= coef_d;
  end

  assign coef_o = coef_q;

endmodule
`default_nettype wire

>>> rtl/axis_angle_vector_rotate_unit.sv
// axis-angle vector rotation, Rodrigues formula, fixed point
// stage registers a..e, then the output register; one vector per cycle when not stalled
// coefficients (axis, sine, cosine) come from a free-running chain of square-root,
// divider and cordic cells fed by the rotation registers; after reset and after
// every register write the input stalls until the settle counter has run down
// reset: asynchronous, active low; rotation registers clear to zero, pipeline empties
`timescale 1ns / 1ps
`default_nettype none
module axis_angle_vector_rotate_unit #(
  parameter int unsigned VEC_WIDTH     = 32,
  parameter int unsigned CORDIC_STAGES = 24
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // configuration write port
  input  wire logic                 cfg_we_i,
  input  wire logic [1:0]           cfg_idx_i,
  input  wire logic [31:0]          cfg_data_i,
  // input vector channel
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [VEC_WIDTH-1:0] vec_x_i,
  input  wire logic [VEC_WIDTH-1:0] vec_y_i,
  input  wire logic [VEC_WIDTH-1:0] vec_z_i,
  // result channel
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [VEC_WIDTH-1:0]      res_x_o,
  output logic [VEC_WIDTH-1:0]      res_y_o,
  output logic [VEC_WIDTH-1:0]      res_z_o,
  output logic                      rotated_o,
  output logic                      saturated_o
);
  import avr_pkg::*;

  localparam int unsigned W      = VEC_WIDTH;
  localparam int unsigned P_W    = W + 1;   // v times unit value
  localparam int unsigned C_W    = W + 2;   // cross product component
  localparam int unsigned D_W    = W + 3;   // dot product and d*k
  localparam int unsigned T_W    = W + 4;   // d*k*(1-cos)
  localparam int unsigned R_W    = W + 6;   // unsaturated result
  localparam int unsigned SETTLE = 72 + CORDIC_STAGES;
  localparam int unsigned CNT_W  = $clog2(SETTLE + 1);
  localparam int unsigned NXT [3] = '{1, 2, 0};
  localparam int unsigned PRV [3] = '{2, 0, 1};

  // rotation registers and settle counter
  logic [31:0]      rot_x_q, rot_y_q, rot_z_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy;
  coef_t            coef;

  // pipeline control: stages a..e, then the output register
  logic [4:0] vld_d, vld_q;
  logic [4:0] adv;
  logic       go_out, accept;
  logic       out_valid_q;

  // stage payloads
  logic signed [W-1:0]   v_a [3], v_b [3], v_c [3], v_d [3], v_e [3];
  logic signed [K_W-1:0] k [3];
  logic signed [W+31:0]  pd [3], pa [3], pb [3], pc [3];
  logic signed [P_W-1:0] diag_q [3], xa_q [3], xb_q [3], vc_b [3], vc_c [3], vc_d [3];
  logic signed [D_W-1:0] dot_q;
  logic signed [C_W-1:0] cr_q [3];
  logic signed [W+34:0]  pdk [3];
  logic signed [W+33:0]  pcs [3];
  logic signed [D_W-1:0] dk_q [3];
  logic signed [C_W-1:0] cs_q [3];
  logic signed [W+35:0]  ptm [3];
  logic signed [T_W-1:0] tm_q [3];
  logic signed [D_W-1:0] pre_q [3];
  logic signed [R_W-1:0] sum [3];
  logic [W-1:0]          res_d [3], res_q [3];
  logic                  sat_d, sat_q, rot_q;
  logic                  clip [3];

  // configuration registers; any write restarts the coefficient settle time
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_x_q <= '0;
      rot_y_q <= '0;
      rot_z_q <= '0;
      cnt_q   <= CNT_W'(SETTLE);
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ROT_X: rot_x_q <= cfg_data_i;
          CFG_ROT_Y: rot_y_q <= cfg_data_i;
          CFG_ROT_Z: rot_z_q <= cfg_data_i;
          default: ;
        endcase
        cnt_q <= CNT_W'(SETTLE);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  assign busy = cnt_q != '0;

  avr_coef #(.CORDIC_STAGES(CORDIC_STAGES)) u_coef (
    .clk_i   (clk_i),
    .rot_x_i (rot_x_q),
    .rot_y_i (rot_y_q),
    .rot_z_i (rot_z_q),
    .coef_o  (coef)
  );

  assign k[0] = coef.k_x;
  assign k[1] = coef.k_y;
  assign k[2] = coef.k_z;

  // a stage moves when it is empty or the stage after it moves
  assign go_out = !out_valid_q || !out_stall_i;

  always_comb begin
    adv[4] = !vld_q[4] || go_out;
    for (int s = 3; s >= 0; s--) begin
      adv[s] = !vld_q[s] || adv[s+1];
    end
  end

  assign in_stall_o = busy || cfg_we_i || !adv[0];
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    vld_d[0] = adv[0] ? accept : vld_q[0];
    for (int s = 1; s < 5; s++) begin
      vld_d[s] = adv[s] ? vld_q[s-1] : vld_q[s];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      vld_q       <= vld_d;
      out_valid_q <= go_out ? vld_q[4] : out_valid_q;
    end
  end

  // products, each floor(p * q / 2^30)
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pd[i]  = v_a[i] * k[i];
      pa[i]  = v_a[PRV[i]] * k[NXT[i]];
      pb[i]  = v_a[NXT[i]] * k[PRV[i]];
      pc[i]  = v_a[i] * coef.cos_v;
      pdk[i] = dot_q * k[i];
      pcs[i] = cr_q[i] * coef.sin_v;
      ptm[i] = dk_q[i] * coef.omc;
      sum[i] = R_W'(pre_q[i]) + R_W'(tm_q[i]);
      // in range when the sign bit and all bits above it agree
      clip[i] = !((&sum[i][R_W-1:W-1]) || !(|sum[i][R_W-1:W-1]));
      if (coef.tiny) begin
        res_d[i] = v_e[i];
      end else if (clip[i]) begin
        res_d[i] = sum[i][R_W-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end else begin
        res_d[i] = sum[i][W-1:0];
      end
    end
    sat_d = !coef.tiny && (clip[0] || clip[1] || clip[2]);
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      v_a[0] <= vec_x_i;
      v_a[1] <= vec_y_i;
      v_a[2] <= vec_z_i;
    end
    for (int i = 0; i < 3; i++) begin
      if (adv[1]) begin
        diag_q[i] <= pd[i][FRAC_W +: P_W];
        xa_q[i]   <= pa[i][FRAC_W +: P_W];
        xb_q[i]   <= pb[i][FRAC_W +: P_W];
        vc_b[i]   <= pc[i][FRAC_W +: P_W];
        v_b[i]    <= v_a[i];
      end
      if (adv[2]) begin
        cr_q[i] <= C_W'(xa_q[i]) - C_W'(xb_q[i]);
        vc_c[i] <= vc_b[i];
        v_c[i]  <= v_b[i];
      end
      if (adv[3]) begin
        dk_q[i] <= pdk[i][FRAC_W +: D_W];
        cs_q[i] <= pcs[i][FRAC_W +: C_W];
        vc_d[i] <= vc_c[i];
        v_d[i]  <= v_c[i];
      end
      if (adv[4]) begin
        tm_q[i]  <= ptm[i][FRAC_W +: T_W];
        pre_q[i] <= D_W'(vc_d[i]) + D_W'(cs_q[i]);
        v_e[i]   <= v_d[i];
      end
      if (go_out) begin
        res_q[i] <= res_d[i];
      end
    end
    if (adv[2]) begin
      dot_q <= D_W'(diag_q[0]) + D_W'(diag_q[1]) + D_W'(diag_q[2]);
    end
    if (go_out) begin
      sat_q <= sat_d;
      rot_q <= !coef.tiny;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_x_o     = res_q[0];
  assign res_y_o     = res_q[1];
  assign res_z_o     = res_q[2];
  assign rotated_o   = rot_q;
  assign saturated_o = sat_q;

endmodule
`default_nettype wire

>>> rtl/avr_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module avr_checker #(
  parameter int unsigned VEC_WIDTH = 32
) (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 cfg_we_i,
  input wire logic                 in_stall_o,
  input wire logic                 out_valid_o,
  input wire logic                 out_stall_i,
  input wire logic [VEC_WIDTH-1:0] res_x_o,
  input wire logic [VEC_WIDTH-1:0] res_y_o,
  input wire logic [VEC_WIDTH-1:0] res_z_o,
  input wire logic                 rotated_o,
  input wire logic                 saturated_o
);

  localparam logic [VEC_WIDTH-1:0] MAX_V = {1'b0, {(VEC_WIDTH-1){1'b1}}};
  localparam logic [VEC_WIDTH-1:0] MIN_V = {1'b1, {(VEC_WIDTH-1){1'b0}}};

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_pass_no_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !rotated_o |-> !saturated_o)
    else $error("saturation flagged on pass-through");

  a_sat_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |->
      res_x_o == MAX_V || res_x_o == MIN_V || res_y_o == MAX_V ||
      res_y_o == MIN_V || res_z_o == MAX_V || res_z_o == MIN_V)
    else $error("saturation flag without clamped component");

  a_cfg_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> in_stall_o)
    else $error("input taken while coefficients settle");

  a_reset_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> in_stall_o)
    else $error("input taken right after reset");

endmodule

bind axis_angle_vector_rotate_unit avr_checker #(.VEC_WIDTH(VEC_WIDTH)) u_avr_checker (.*);
`default_nettype wire
